// ===== design/pcg_pkg.sv =====
// Shared types and constants for the path component generation table.
package pcg_pkg;

  localparam int KEY_W  = 32;
  localparam int BYTE_W = 8;
  localparam int CMD_QUEUE_DEPTH = 2;

  localparam logic [KEY_W-1:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [KEY_W-1:0] FNV_PRIME = 32'h0100_0193;

  localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_FOLD  = 8'h20;

  typedef enum logic [1:0] {
    KIND_HASH      = 2'd0,
    KIND_HASH_BUMP = 2'd1,
    KIND_READ      = 2'd2,
    KIND_BUMP      = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] path_byte;
    logic              last;
    logic [KEY_W-1:0]  lookup_key;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0] component_key;
    logic [KEY_W-1:0] generation;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             bump;
  } cmd_t;

endpackage

// ===== design/path_component_generation_table_core.sv =====
// Top level of the path component generation table.
//
// Input channel: an item (req) is taken at a rising edge with start high and
// busy low. Kinds 0 and 1 stream one path byte per beat; the beat with last
// set ends the path. Kinds 2 and 3 read or bump a counter by lookup_key.
// Result channel: done is high for exactly one cycle with rsp valid; the
// receiver cannot stall, so a result is delivered in that cycle.
// Path: once the back end is free, a beat's result passes through the queue,
// multiply, quotient, remainder, counter read and counter update steps, then
// the result strobe.
// Throughput: while busy is low, path bytes that end no path are taken one per
// cycle. Each result occupies the back end through key mod SLOT_COUNT by
// reciprocal multiplication and the counter RAM read-modify-write; a two-entry
// command queue lets the front keep taking beats until it fills, then busy rises.
// Reset: path hash state returns to the offset basis and a clearing pass
// writes zero to all SLOT_COUNT counters, one per cycle; busy stays high until
// the pass ends.
module path_component_generation_table_core #(
  parameter int SLOT_COUNT = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pcg_pkg::req_t req,
  output logic          done,
  output pcg_pkg::rsp_t rsp
);

  logic          accept;
  logic          push;
  pcg_pkg::cmd_t push_cmd;
  pcg_pkg::cmd_t head;
  logic          head_valid;
  logic          queue_full;
  logic          pop;
  logic          clearing;

  assign busy   = clearing || queue_full;
  assign accept = start && !busy;

  pcg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req     (req),
    .push    (push),
    .push_cmd(push_cmd)
  );

  pcg_cmd_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .valid   (head_valid),
    .full    (queue_full)
  );

  pcg_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(head_valid),
    .cmd      (head),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .rsp      (rsp)
  );

endmodule

// ===== design/pcg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pcg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pcg_front.sv =====
// Front end: path hashing and command classification.
module pcg_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  pcg_pkg::req_t req,
  output logic          push,
  output pcg_pkg::cmd_t push_cmd
);

  logic [pcg_pkg::KEY_W-1:0]  running_hash, running_hash_next;
  logic [pcg_pkg::KEY_W-1:0]  hash_before_seps, hash_before_seps_next;
  logic                       in_sep_run, in_sep_run_next;
  logic [pcg_pkg::BYTE_W-1:0] folded;
  logic                       hashing;
  logic [pcg_pkg::KEY_W-1:0]  path_key;

  always_comb begin
    running_hash_next     = running_hash;
    hash_before_seps_next = hash_before_seps;
    in_sep_run_next       = in_sep_run;
    folded                = req.path_byte;
    if (req.path_byte inside {[pcg_pkg::CH_UPPER_A:pcg_pkg::CH_UPPER_Z]}) begin
      folded = req.path_byte + pcg_pkg::CASE_FOLD;
    end
    if (req.path_byte == pcg_pkg::CH_SLASH || req.path_byte == pcg_pkg::CH_BSLASH) begin
      if (!in_sep_run) begin
        hash_before_seps_next = running_hash;
      end
      in_sep_run_next   = 1'b1;
      running_hash_next = pcg_pkg::FNV_BASIS;
    end else if (req.path_byte == pcg_pkg::CH_COLON) begin
      in_sep_run_next   = 1'b0;
      running_hash_next = pcg_pkg::FNV_BASIS;
    end else begin
      running_hash_next = (running_hash ^ {{(pcg_pkg::KEY_W-pcg_pkg::BYTE_W){1'b0}}, folded})
                          * pcg_pkg::FNV_PRIME;
      in_sep_run_next   = 1'b0;
    end
    path_key = in_sep_run_next ? hash_before_seps_next : running_hash_next;
  end

  assign hashing = (req.kind == pcg_pkg::KIND_HASH) || (req.kind == pcg_pkg::KIND_HASH_BUMP);
  assign push    = accept && (!hashing || req.last);
  assign push_cmd.key  = hashing ? path_key : req.lookup_key;
  assign push_cmd.bump = (req.kind == pcg_pkg::KIND_HASH_BUMP) ||
                         (req.kind == pcg_pkg::KIND_BUMP);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash     <= pcg_pkg::FNV_BASIS;
      hash_before_seps <= pcg_pkg::FNV_BASIS;
      in_sep_run       <= 1'b0;
    end else if (accept && hashing) begin
      if (req.last) begin
        running_hash     <= pcg_pkg::FNV_BASIS;
        hash_before_seps <= pcg_pkg::FNV_BASIS;
        in_sep_run       <= 1'b0;
      end else begin
        running_hash     <= running_hash_next;
        hash_before_seps <= hash_before_seps_next;
        in_sep_run       <= in_sep_run_next;
      end
    end
  end

endmodule

// ===== design/pcg_cmd_fifo.sv =====
// Short command queue between front and back.
module pcg_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pcg_pkg::cmd_t push_cmd,
  input  logic          pop,
  output pcg_pkg::cmd_t head,
  output logic          valid,
  output logic          full
);

  localparam int DEPTH = pcg_pkg::CMD_QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  pcg_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head  = entries[rd_ptr];
  assign valid = (count != '0);
  assign full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/pcg_back.sv =====
// Back end: slot reduction, counter read-modify-write, result strobe.
module pcg_back #(
  parameter int SLOT_COUNT = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  pcg_pkg::cmd_t cmd,
  output logic          pop,
  output logic          clearing,
  output logic          done,
  output pcg_pkg::rsp_t rsp
);

  localparam int KW     = pcg_pkg::KEY_W;
  localparam int PW     = 2 * KW;
  localparam int AW     = $clog2(SLOT_COUNT);
  localparam int QSHIFT = AW - 1;
  localparam logic [AW-1:0] LAST_SLOT  = AW'(SLOT_COUNT - 1);
  localparam logic [KW-1:0] DIVISOR    = KW'(SLOT_COUNT);
  localparam logic [PW-1:0] ONE        = PW'(1);
  localparam logic [PW-1:0] SLOTS_WIDE = PW'(SLOT_COUNT);
  // reciprocal for unsigned key / SLOT_COUNT
  localparam logic [PW-1:0] MAGIC_WIDE =
    ((ONE << KW) * ((ONE << AW) - SLOTS_WIDE)) / SLOTS_WIDE + ONE;
  localparam logic [KW-1:0] MAGIC = KW'(MAGIC_WIDE);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MUL, S_QUO, S_REM, S_READ, S_UPD} state_t;

  state_t        state;
  logic [KW-1:0] key;
  logic          bump;
  logic [PW-1:0] prod;
  logic [KW-1:0] est;
  logic [KW-1:0] quo;
  logic [KW-1:0] quo_next;
  logic [AW-1:0] rem;
  logic [AW-1:0] clr_addr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KW-1:0] ram_wdata;
  logic [KW-1:0] ram_rdata;
  logic [KW-1:0] gen_new;

  // key mod SLOT_COUNT: multiply high word, quotient fixup, remainder
  assign prod     = PW'(key) * PW'(MAGIC);
  assign quo_next = (est + ((key - est) >> 1)) >> QSHIFT;

  assign gen_new   = ram_rdata + {{(KW-1){1'b0}}, bump};
  assign clearing  = (state == S_CLEAR);
  assign pop       = (state == S_IDLE) && cmd_valid;
  assign ram_we    = clearing || ((state == S_UPD) && bump);
  assign ram_waddr = clearing ? clr_addr : rem;
  assign ram_wdata = clearing ? '0 : gen_new;

  pcg_ram #(
    .WIDTH(pcg_pkg::KEY_W),
    .DEPTH(SLOT_COUNT)
  ) u_counters (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rem),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            key   <= cmd.key;
            bump  <= cmd.bump;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          est   <= prod[PW-1:KW];
          state <= S_QUO;
        end
        S_QUO: begin
          quo   <= quo_next;
          state <= S_REM;
        end
        S_REM: begin
          rem   <= AW'(key - quo * DIVISOR);
          state <= S_READ;
        end
        S_READ: begin
          state <= S_UPD;
        end
        S_UPD: begin
          done              <= 1'b1;
          rsp.component_key <= key;
          rsp.generation    <= gen_new;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_UPD) |-> (rem <= LAST_SLOT))
    else $error("slot remainder out of range");

  a_done_after_upd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPD))
    else $error("result strobe without counter update");

  a_rem_to_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM) |=> (state == S_READ))
    else $error("slot reduction did not reach the counter read");

  a_no_pop_while_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!pop && !done))
    else $error("command taken during clearing pass");

endmodule

// ===== test/path_component_generation_table_checker.sv =====
// Checker: predicts path component keys and slot generations, compares each result beat.
module path_component_generation_table_checker
  import pcg_pkg::*;
#(
  parameter int SLOT_COUNT = 256
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  busy,
  input  req_t  req,
  input  logic  done,
  input  rsp_t  rsp,
  output int    errors,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [KEY_W-1:0] name_hash;
  logic [KEY_W-1:0] hash_before_run;
  logic             sep_run;
  logic [KEY_W-1:0] generations [SLOT_COUNT];
  rsp_t             expected_rsp [$];
  rsp_t             oldest;

  task automatic clear_path();
    name_hash = FNV_BASIS;
    hash_before_run = FNV_BASIS;
    sep_run = 1'b0;
  endtask

  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = b;
    if (b == CH_SLASH || b == CH_BSLASH) begin
      if (!sep_run) hash_before_run = name_hash;
      sep_run = 1'b1;
      name_hash = FNV_BASIS;
    end else if (b == CH_COLON) begin
      sep_run = 1'b0;
      name_hash = FNV_BASIS;
    end else begin
      if (b >= CH_UPPER_A && b <= CH_UPPER_Z) c = b + 8'd32;
      name_hash = (name_hash ^ {24'd0, c}) * FNV_PRIME;
      sep_run = 1'b0;
    end
  endtask

  task automatic predict_beat(input req_t r);
    logic [KEY_W-1:0] key;
    int               slot;
    rsp_t             e;
    if (r.kind == KIND_HASH || r.kind == KIND_HASH_BUMP) begin
      absorb_byte(r.path_byte);
      if (!r.last) return;
      key = sep_run ? hash_before_run : name_hash;
      clear_path();
    end else begin
      key = r.lookup_key;
    end
    slot = int'(key % 32'(SLOT_COUNT));
    if (r.kind == KIND_HASH_BUMP || r.kind == KIND_BUMP) generations[slot] += 32'd1;
    e.component_key = key;
    e.generation = generations[slot];
    expected_rsp.push_back(e);
  endtask

  task automatic report(input string what, input logic [KEY_W-1:0] want,
                        input logic [KEY_W-1:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_path();
      for (int i = 0; i < SLOT_COUNT; i++) generations[i] = '0;
      expected_rsp.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result beat, expected none, actual key %h gen %h",
                   $time, rsp.component_key, rsp.generation);
        end else begin
          oldest = expected_rsp.pop_front();
          if (rsp.component_key !== oldest.component_key)
            report("component_key", oldest.component_key, rsp.component_key);
          if (rsp.generation !== oldest.generation)
            report("generation", oldest.generation, rsp.generation);
        end
      end
      if (start && !busy) predict_beat(req);
    end
    pending = expected_rsp.size();
  end

endmodule

// ===== test/path_component_generation_table_core_tb.sv =====
// Testbench top: drives path and lookup beats with random gaps and gives the verdict.
module path_component_generation_table_core_tb
  import pcg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req = '0;
  rsp_t rsp;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   beat_count = 0;
  int   idle_pct = 0;
  string letters = "aAbBzZ";

  path_component_generation_table_core #(.SLOT_COUNT(SLOT_COUNT)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp)
  );

  path_component_generation_table_checker #(.SLOT_COUNT(SLOT_COUNT)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp),
    .errors(errors), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic req_t noise_beat();
    req_t r;
    r.kind = kind_t'($urandom_range(3));
    r.path_byte = 8'($urandom_range(255));
    r.last = ($urandom_range(7) == 0);
    r.lookup_key = $urandom;
    return r;
  endfunction

  function automatic req_t path_beat(input kind_t k, input logic [7:0] b, input logic lst);
    req_t r;
    r = noise_beat();
    r.kind = k;
    r.path_byte = b;
    r.last = lst;
    return r;
  endfunction

  function automatic req_t key_beat(input kind_t k, input logic [31:0] key);
    req_t r;
    r = noise_beat();
    r.kind = k;
    r.lookup_key = key;
    return r;
  endfunction

  function automatic logic [31:0] random_key();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return FNV_BASIS;
    if (sel < 3) return 32'($urandom_range(255));
    return $urandom;
  endfunction

  // hold a beat until accepted; gaps inserted ahead of it at idle_pct percent
  task automatic send_beat(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      req <= noise_beat();
    end
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    beat_count++;
  endtask

  task automatic send_path(input string s, input kind_t k);
    for (int i = 0; i < s.len(); i++) send_beat(path_beat(k, s[i], i == s.len() - 1));
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
      start <= 1'b0;
    end while (pending != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic send_random_path();
    int          n;
    int          sel;
    logic [7:0]  b;
    kind_t       k;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_beat(key_beat($urandom_range(1) ? KIND_BUMP : KIND_READ, random_key()));
      sel = $urandom_range(99);
      if (sel < 30) b = letters[$urandom_range(letters.len() - 1)];
      else if (sel < 50) b = $urandom_range(1) ? CH_SLASH : CH_BSLASH;
      else if (sel < 58) b = CH_COLON;
      else b = 8'($urandom_range(255));
      k = $urandom_range(1) ? KIND_HASH_BUMP : KIND_HASH;
      send_beat(path_beat(k, b, i == n - 1));
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: empty components, case folding, separators, byte extremes
    send_path("/", KIND_HASH);
    send_path("Ab\\", KIND_HASH_BUMP);
    send_path("x:", KIND_HASH);
    send_path("q:/", KIND_HASH_BUMP);
    send_beat(path_beat(KIND_HASH, 8'h00, 1'b0));
    send_beat(path_beat(KIND_HASH, 8'h40, 1'b0));
    send_beat(path_beat(KIND_HASH, 8'h5B, 1'b0));
    send_beat(path_beat(KIND_HASH_BUMP, 8'hFF, 1'b1));
    // lookups in the middle of a path
    send_beat(path_beat(KIND_HASH_BUMP, "Z", 1'b0));
    send_beat(key_beat(KIND_BUMP, 32'hFFFF_FFFF));
    send_beat(key_beat(KIND_READ, 32'h0000_0000));
    send_beat(path_beat(KIND_HASH, CH_SLASH, 1'b0));
    send_beat(path_beat(KIND_HASH_BUMP, "z", 1'b1));
    send_beat(key_beat(KIND_READ, 32'h0000_0100));
    send_beat(key_beat(KIND_BUMP, 32'h0000_00FF));
    send_beat(key_beat(KIND_READ, FNV_BASIS));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 16 : (phase == 1) ? 73 : 0;
      while (beat_count < 25 + 650 * (phase + 1)) begin
        case ($urandom_range(19))
          0, 1, 2: send_beat(key_beat($urandom_range(1) ? KIND_BUMP : KIND_READ,
                                      random_key()));
          3, 4:    send_beat(noise_beat());
          default: send_random_path();
        endcase
      end
      // flush any open path so the next phase starts clean
      send_beat(path_beat(KIND_HASH, CH_COLON, 1'b1));
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
